FILE: hdl/mode_select_task_deque_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the task deque
// Clocked on clk, switched off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MODE_SELECT_TASK_DEQUE_ASSERT_SVH
`define MODE_SELECT_TASK_DEQUE_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define MSTD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mstd: same-cycle check failed");

// Consequent in the cycle after the antecedent.
`define MSTD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mstd: next-cycle check failed");

`endif

FILE: hdl/mstd_pkg.sv
// ---------------------------------------------------------------------------
// mstd_pkg
// Shared op codes, field widths and the controller command bundle.
// ---------------------------------------------------------------------------
package mstd_pkg;

	localparam int OP_W       = 2;
	localparam int TASK_OUT_W = 32;
	localparam int OCC_W      = 5;

	localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OP_W-1:0] OP_POP   = 2'd1;
	localparam logic [OP_W-1:0] OP_STEAL = 2'd2;

	typedef struct packed {
		logic take;      // accept input item, run the access
		logic load_out;  // move stage-1 result into the output register
	} mstd_cmd_t;

endpackage

FILE: hdl/mstd_ctrl.sv
// ---------------------------------------------------------------------------
// mstd_ctrl
// Handshake controller: tracks stage 1 and the output register.
// ---------------------------------------------------------------------------
`include "mode_select_task_deque_assert.svh"

module mstd_ctrl import mstd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output mstd_cmd_t cmd
);

	// state = {stage-1 full, output register full}
	localparam logic [1:0] ST_IDLE = 2'b00;
	localparam logic [1:0] ST_OUT  = 2'b01;
	localparam logic [1:0] ST_S1   = 2'b10;
	localparam logic [1:0] ST_BOTH = 2'b11;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       s1_full;
	logic       out_full;

	always_comb begin
		s1_full  = 1'b0;
		out_full = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s1_full  = 1'b0;
				out_full = 1'b0;
			end
			ST_OUT: begin
				s1_full  = 1'b0;
				out_full = 1'b1;
			end
			ST_S1: begin
				s1_full  = 1'b1;
				out_full = 1'b0;
			end
			ST_BOTH: begin
				s1_full  = 1'b1;
				out_full = 1'b1;
			end
			default: begin
				s1_full  = 1'b0;
				out_full = 1'b0;
			end
		endcase
	end

	assign cmd.load_out = s1_full & (~out_full | out_ready);
	assign in_ready     = ~s1_full | cmd.load_out;
	assign cmd.take     = in_valid & in_ready;
	assign out_valid    = out_full;

	assign state_nxt = {cmd.take | (s1_full & ~cmd.load_out),
	                    cmd.load_out | (out_full & ~out_ready)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	`MSTD_ASSERT_NEXT(a_take_fills_s1, cmd.take, state_q[1])
	`MSTD_ASSERT_NEXT(a_s1_drains, state_q == ST_S1, state_q[0])

endmodule

FILE: hdl/mstd_dpath.sv
// ---------------------------------------------------------------------------
// mstd_dpath
// Circular task store, front/back pointers, count and result registers.
// ---------------------------------------------------------------------------
`include "mode_select_task_deque_assert.svh"

module mstd_dpath import mstd_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int TASK_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  mstd_cmd_t             cmd,
	input  logic [OP_W-1:0]       op,
	input  logic [TASK_OUT_W-1:0] task_word,
	output logic                  accepted,
	output logic [TASK_OUT_W-1:0] task_out,
	output logic [OCC_W-1:0]      occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic                  push_at_front_q;
	logic [AW-1:0]         front_q;
	logic [AW-1:0]         back_q;
	logic [CW-1:0]         count_q;

	logic [TASK_WIDTH-1:0] mem [DEPTH];

	logic                  ok_s1;
	logic                  take_s1;
	logic [CW-1:0]         occ_s1;
	logic [TASK_WIDTH-1:0] rd_data_s1;

	logic                  accepted_q;
	logic [TASK_OUT_W-1:0] task_q;
	logic [OCC_W-1:0]      occ_q;

	logic                  is_push, is_pop, is_steal;
	logic                  push_ok, take_ok;
	logic [AW-1:0]         front_up, front_dn, back_up, back_dn;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic [CW-1:0]         count_nxt;

	logic [TASK_WIDTH+TASK_OUT_W-1:0] wr_ext;
	logic [TASK_WIDTH+TASK_OUT_W-1:0] rd_ext;
	logic [CW+OCC_W-1:0]              occ_ext;

	assign is_push  = (op == OP_PUSH);
	assign is_pop   = (op == OP_POP);
	assign is_steal = (op == OP_STEAL);
	assign push_ok  = is_push & (count_q != FULL_CNT);
	assign take_ok  = (is_pop | is_steal) & (count_q != '0);

	// modulo-DEPTH stepping, DEPTH need not be a power of two
	assign front_up = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign front_dn = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign back_up  = (back_q == LAST_IDX) ? '0 : back_q + 1'b1;
	assign back_dn  = (back_q == '0) ? LAST_IDX : back_q - 1'b1;

	assign wr_addr = push_at_front_q ? front_dn : back_q;
	assign rd_addr = is_pop ? front_q : back_dn;

	assign wr_ext = {{TASK_WIDTH{1'b0}}, task_word};

	always_comb begin
		count_nxt = count_q;
		if (push_ok) begin
			count_nxt = count_q + 1'b1;
		end else if (take_ok) begin
			count_nxt = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_at_front_q <= 1'b0;
		end else if (cfg_we) begin
			push_at_front_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (cmd.take) begin
			count_q <= count_nxt;
			if (push_ok) begin
				if (push_at_front_q) begin
					front_q <= front_dn;
				end else begin
					back_q <= back_up;
				end
			end else if (take_ok) begin
				if (is_pop) begin
					front_q <= front_up;
				end else begin
					back_q <= back_dn;
				end
			end
		end
	end

	// task store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.take & push_ok) begin
			mem[wr_addr] <= wr_ext[TASK_WIDTH-1:0];
		end
		if (cmd.take & take_ok) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			ok_s1   <= push_ok | take_ok;
			take_s1 <= take_ok;
			occ_s1  <= count_nxt;
		end
	end

	assign rd_ext  = {{TASK_OUT_W{1'b0}}, rd_data_s1};
	assign occ_ext = {{OCC_W{1'b0}}, occ_s1};

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			accepted_q <= ok_s1;
			task_q     <= take_s1 ? rd_ext[TASK_OUT_W-1:0] : '0;
			occ_q      <= occ_ext[OCC_W-1:0];
		end
	end

	assign accepted  = accepted_q;
	assign task_out  = task_q;
	assign occupancy = occ_q;

	`MSTD_ASSERT_SAME(a_count_bound, 1'b1, count_q <= FULL_CNT)
	`MSTD_ASSERT_SAME(a_full_ptrs, count_q == FULL_CNT || count_q == '0, front_q == back_q)
	`MSTD_ASSERT_NEXT(a_take_dec, cmd.take && take_ok, count_q == $past(count_q) - 1'b1)

endmodule

FILE: hdl/mode_select_task_deque.sv
// ---------------------------------------------------------------------------
// mode_select_task_deque
// Bounded double-ended task queue with push-to-front (LIFO) or push-to-back
// selected by a configuration bit; pop takes the front, steal the back.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  input    | in_valid / in_ready    | op, task_word
//  result   | out_valid / out_ready  | accepted, task_out, occupancy
//  config   | cfg_we (no wait)       | cfg_wdata -> push_at_front
//
//  out_valid rises once the result has passed stage 1 (the registered
//  task store read) and been loaded into the output register.
//  One transfer per cycle is sustained while out_ready stays high.
//  A stalled result waits in the output register while stage 1 takes one
//  further access; in_ready drops only when both are full.
//  Asynchronous active-low reset empties the queue and clears push_at_front.
// ---------------------------------------------------------------------------
module mode_select_task_deque import mstd_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int TASK_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	// input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [OP_W-1:0]       op,
	input  logic [TASK_OUT_W-1:0] task_word,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  accepted,
	output logic [TASK_OUT_W-1:0] task_out,
	output logic [OCC_W-1:0]      occupancy
);

	mstd_cmd_t cmd;

	// controller: owns the valid/ready bookkeeping of stage 1 and output
	mstd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// datapath: pointers, count, task store and result registers
	mstd_dpath #(
		.DEPTH      (DEPTH),
		.TASK_WIDTH (TASK_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.op        (op),
		.task_word (task_word),
		.accepted  (accepted),
		.task_out  (task_out),
		.occupancy (occupancy)
	);

endmodule

FILE: tb/tb_mode_select_task_deque.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_mode_select_task_deque
// Self-checking bench for the bounded task deque. A queue-fed driver sends
// push, pop, steal and unused-code accesses in random bursts. A shadow deque
// predicts each result at its input transfer. A monitor with its own stall
// pattern compares every result transfer against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_mode_select_task_deque;
	import mstd_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 194;
	localparam int STALL_LIMIT = 4000;
	localparam int REPORT_MAX  = 10;

	// op code 3 has no meaning; the block still answers it
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic                  accepted;
		logic [TASK_OUT_W-1:0] task_out;
		logic [OCC_W-1:0]      occupancy;
	} access_result_t;

	typedef struct packed {
		logic [OP_W-1:0]       code;
		logic [TASK_OUT_W-1:0] word;
	} access_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic                  cfg_wdata = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [OP_W-1:0]       op        = '0;
	logic [TASK_OUT_W-1:0] task_word = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  accepted;
	logic [TASK_OUT_W-1:0] task_out;
	logic [OCC_W-1:0]      occupancy;

	mode_select_task_deque #(
		.DEPTH      (QUEUE_DEPTH),
		.TASK_WIDTH (TASK_OUT_W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.task_word (task_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.accepted  (accepted),
		.task_out  (task_out),
		.occupancy (occupancy)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// -----------------------------------------------------------------------
	// Shadow deque: circular store, head = front entry, tail = one past back
	// -----------------------------------------------------------------------
	logic [TASK_OUT_W-1:0] task_ring [QUEUE_DEPTH];
	logic [IDX_W-1:0]      ring_head = '0;
	logic [IDX_W-1:0]      ring_tail = '0;
	int                    ring_fill = 0;
	bit                    lifo_mode = 1'b0;

	access_t        pending_accesses [$];
	access_result_t predicted_results [$];
	access_t        next_access;
	access_result_t due;

	int mismatches  = 0;
	int idle_cycles = 0;

	// One access against the shadow deque. Full push and empty pop/steal
	// leave everything alone; the unused code falls through to the default.
	function automatic access_result_t apply_access(input logic [OP_W-1:0] code,
			input logic [TASK_OUT_W-1:0] word);
		access_result_t res;
		res = '0;
		case (code)
		OP_PUSH: begin
			if (ring_fill < QUEUE_DEPTH) begin
				if (lifo_mode) begin
					ring_head = ring_head - 1'b1;
					task_ring[ring_head] = word;
				end else begin
					task_ring[ring_tail] = word;
					ring_tail = ring_tail + 1'b1;
				end
				ring_fill++;
				res.accepted = 1'b1;
			end
		end
		OP_POP: begin
			if (ring_fill > 0) begin
				res.task_out = task_ring[ring_head];
				ring_head = ring_head + 1'b1;
				ring_fill--;
				res.accepted = 1'b1;
			end
		end
		OP_STEAL: begin
			if (ring_fill > 0) begin
				ring_tail = ring_tail - 1'b1;
				res.task_out = task_ring[ring_tail];
				ring_fill--;
				res.accepted = 1'b1;
			end
		end
		default: ;
		endcase
		res.occupancy = ring_fill[OCC_W-1:0];
		return res;
	endfunction

	// -----------------------------------------------------------------------
	// Driver: bursts of random length, random gaps between them. The
	// prediction is taken at the input transfer from the values then on the
	// port, so it follows the block's own order of accesses.
	// -----------------------------------------------------------------------
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted_results.insert(predicted_results.size(),
					apply_access(op, task_word));
			end
			if (in_valid && !in_ready) begin
				// held until transfer, payload untouched
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_accesses.size() != 0) begin
				next_access = pending_accesses[0];
				pending_accesses.delete(0);
				in_valid  <= 1'b1;
				op        <= next_access.code;
				task_word <= next_access.word;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// now and then a long back-to-back stretch
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
						: $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Monitor: ready pattern changes its duty every stretch of cycles, from
	// never stalling down to mostly stalled.
	// -----------------------------------------------------------------------
	int ready_pct  = 100;
	int ready_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: unexpected result %0b/%h/%0d",
							$realtime, accepted, task_out, occupancy);
				end else begin
					due = predicted_results[0];
					predicted_results.delete(0);
					if (accepted !== due.accepted || task_out !== due.task_out
							|| occupancy !== due.occupancy) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("%0t: mismatch exp %0b/%h/%0d got %0b/%h/%0d",
								$realtime, due.accepted, due.task_out, due.occupancy,
								accepted, task_out, occupancy);
					end
				end
			end
			if (ready_left == 0) begin
				case ($urandom_range(0, 4))
				0, 1:    ready_pct = 100;
				2:       ready_pct = 80;
				3:       ready_pct = 50;
				default: ready_pct = 20;
				endcase
				ready_left = $urandom_range(20, 200);
			end else begin
				ready_left--;
			end
			out_ready <= ($urandom_range(0, 99) < ready_pct);
		end
	end

	// Watchdog: too long without any transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus
	// -----------------------------------------------------------------------
	task automatic queue_access(input logic [OP_W-1:0] code,
			input logic [TASK_OUT_W-1:0] word);
		access_t a;
		a.code = code;
		a.word = word;
		pending_accesses.insert(pending_accesses.size(), a);
	endtask

	// only called with the block idle; predictor follows the write edge
	task automatic set_mode(input bit lifo);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= lifo;
		@(posedge clk);
		cfg_we <= 1'b0;
		lifo_mode = lifo;
		@(negedge clk);
	endtask

	// sampled on the falling edge, clear of the driver's updates
	task automatic wait_idle();
		while (pending_accesses.size() != 0 || in_valid || predicted_results.size() != 0)
			@(negedge clk);
	endtask

	// Segments of biased traffic so the deque swings between empty and full;
	// a few percent unused codes as noise.
	task automatic queue_random_phase(input int count);
		int seg_left;
		int push_pct;
		int r;
		logic [TASK_OUT_W-1:0] word;
		seg_left = 0;
		push_pct = 50;
		repeat (count) begin
			if (seg_left == 0) begin
				case ($urandom_range(0, 4))
				0:       push_pct = 90;
				1:       push_pct = 75;
				2:       push_pct = 50;
				3:       push_pct = 25;
				default: push_pct = 10;
				endcase
				seg_left = $urandom_range(8, 48);
			end
			seg_left--;
			case ($urandom_range(0, 15))
			0:       word = '0;
			1:       word = '1;
			default: word = $urandom;
			endcase
			r = $urandom_range(0, 99);
			if (r < 3)
				queue_access(OP_UNUSED, word);
			else if (r < 3 + push_pct * 97 / 100)
				queue_access(OP_PUSH, word);
			else if ($urandom_range(0, 1) == 0)
				queue_access(OP_POP, word);
			else
				queue_access(OP_STEAL, word);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// back-push mode: empty takes, unused code, extreme handles
		set_mode(1'b0);
		queue_access(OP_POP, 32'h1234_5678);
		queue_access(OP_STEAL, '1);
		queue_access(OP_UNUSED, '1);
		queue_access(OP_PUSH, '0);
		queue_access(OP_PUSH, '1);
		queue_access(OP_POP, '1);
		queue_access(OP_UNUSED, '0);
		queue_access(OP_STEAL, '0);
		wait_idle();

		// front-push mode: fill up, push into full, take from both ends
		set_mode(1'b1);
		for (int i = 0; i < QUEUE_DEPTH; i++)
			queue_access(OP_PUSH, (i == 0) ? 32'hA5A5_5A5A : $urandom);
		queue_access(OP_PUSH, 32'hDEAD_0001);
		queue_access(OP_POP, '0);
		queue_access(OP_STEAL, '0);
		wait_idle();

		// random phases; the deque keeps its contents across mode changes
		for (int ph = 0; ph < PHASES; ph++) begin
			set_mode((ph < 2) ? ph[0] : 1'($urandom_range(0, 1)));
			queue_random_phase(PHASE_ITEMS);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/mstd_pkg.sv
hdl/mstd_ctrl.sv
hdl/mstd_dpath.sv
hdl/mode_select_task_deque.sv
tb/tb_mode_select_task_deque.sv
